@@ sv/lsa_pkg.sv @@
// ----------------------------------------------------------------------------
// lsa_pkg: shared types and constants for link-state advert acceptance
// Holds the action and state codes, register indices and the per-cell entry record.
// ----------------------------------------------------------------------------
`default_nettype none
package lsa_pkg;

  typedef enum logic [2:0] {
    ACT_DROP     = 3'd0,
    ACT_ADDED    = 3'd1,
    ACT_STALE    = 3'd2,
    ACT_NEWER    = 3'd3,
    ACT_FLOOD    = 3'd4,
    ACT_LCL_FLD  = 3'd5,
    ACT_LCL_DROP = 3'd6,
    ACT_FULL     = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_OUT
  } state_e;

  localparam int unsigned REG_LOCAL_ID = 0;
  localparam int unsigned REG_FRESH    = 1;
  localparam logic [29:0] FRESH_RESET  = 30'd3000000;

  typedef struct packed {
    logic [47:0] near_key;
    logic [47:0] far_key;
    logic [55:0] payload;
    logic [31:0] seq;
    logic [31:0] stamp;
  } entry_t;

  // control given to every cell of the chain alongside the rotating entries
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ sv/lsa_cell.sv @@
// ----------------------------------------------------------------------------
// lsa_cell: one table slot of the rotating entry ring
// Holds one entry and its valid bit; on shift takes its upstream neighbor's
// contents, on load takes the entry offered at the ring head.
// ----------------------------------------------------------------------------
`default_nettype none
module lsa_cell
  import lsa_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cell_ctl_t  ctl_i,
  input  wire        head_i,
  input  entry_t     new_entry_i,
  input  wire        prev_valid_i,
  input  entry_t     prev_entry_i,
  output logic       valid_o,
  output entry_t     entry_o
);

  logic   valid_q;
  entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load && head_i) begin
      valid_q <= 1'b1;
    end else if (ctl_i.shift) begin
      valid_q <= prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load && head_i) begin
      entry_q <= new_entry_i;
    end else if (ctl_i.shift) begin
      entry_q <= prev_entry_i;
    end
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule
`default_nettype wire

@@ sv/link_state_advert_accept.sv @@
// ----------------------------------------------------------------------------
// link_state_advert_accept: link-state advert table lookup and update
// Table entries sit in a ring of cells that rotates one slot per cycle, while
// scanning or writing back, past a compare point at the ring head.
// ----------------------------------------------------------------------------
//  channel | signals                      | direction
//  in      | in_valid_i / in_ready_o      | advert in
//  out     | out_valid_o / out_ready_i    | decision and advert to send
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i | register write
//
//  An advert without a table write passes the accept state, a full ring
//  rotation in the scan state, one decide state and the output state. A
//  write (add, stale, newer) adds a second ring rotation in the output
//  state. Reset empties the table at once. A stalled result holds the
//  block in its output state; the next advert is taken once the result is
//  accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module link_state_advert_accept
  import lsa_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [0:0]  cfg_idx_i,
  input  wire  [31:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [31:0] in_rt_id_i,
  input  wire  [15:0] in_if_id_i,
  input  wire  [31:0] in_n_rt_id_i,
  input  wire  [15:0] in_n_if_id_i,
  input  wire  [31:0] in_addr_i,
  input  wire  [15:0] in_metric_i,
  input  wire  [7:0]  in_link_state_i,
  input  wire  [31:0] in_seq_i,
  input  wire  [31:0] now_us_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [2:0]  action_o,
  output logic [31:0] out_rt_id_o,
  output logic [15:0] out_if_id_o,
  output logic [31:0] out_n_rt_id_o,
  output logic [15:0] out_n_if_id_o,
  output logic [31:0] out_addr_o,
  output logic [15:0] out_metric_o,
  output logic [7:0]  out_link_state_o,
  output logic [31:0] out_seq_o
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [31:0] local_id_q;
  logic [29:0] fresh_q;
  logic [31:0] limit_q;  // floor(fresh*1.5), fits in 31 bits

  state_e   state_q, state_d;
  logic [CW-1:0] cnt_q;
  entry_t   adv_q;       // incoming advert, stamp = now
  logic     hit_q, free_q;
  logic [CW-1:0] hit_pos_q, free_pos_q;
  entry_t   hit_ent_q;
  logic [2:0] act_q;
  entry_t   res_q;

  cell_ctl_t ctl;
  logic      head_load;
  logic [ENTRIES-1:0] valid;
  entry_t    ent [ENTRIES];

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_id_q <= '0;
      fresh_q    <= FRESH_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == 1'(REG_LOCAL_ID)) begin
        local_id_q <= cfg_data_i;
      end else begin
        fresh_q <= cfg_data_i[29:0];
      end
    end
  end

  // x1.5 via shift-add; stays below 2^31
  always_ff @(posedge clk_i) begin
    limit_q <= {2'b0, fresh_q} + {3'b0, fresh_q[29:1]};
  end

  // cell at index 0 is the ring head; cell i takes from cell i-1, head from last
  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      lsa_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (ctl),
        .head_i       (head_load && (g == 0)),
        .new_entry_i  (res_q),
        .prev_valid_i (valid[(g + ENTRIES - 1) % ENTRIES]),
        .prev_entry_i (ent[(g + ENTRIES - 1) % ENTRIES]),
        .valid_o      (valid[g]),
        .entry_o      (ent[g])
      );
    end
  endgenerate

  // The entry at the head at scan step k is original slot (ENTRIES-k)%ENTRIES;
  // slot order k'=(ENTRIES-k)%ENTRIES. Rank by slot number.
  logic [CW-1:0] slot;
  assign slot = (cnt_q == '0) ? '0 : CW'(ENTRIES) - cnt_q;

  logic key_eq;
  assign key_eq = valid[0] && ent[0].near_key == adv_q.near_key
                  && ent[0].far_key == adv_q.far_key;

  // write-back: during the second rotation in the output state, load at the head when the target slot passes
  logic [CW-1:0] wr_slot;
  logic          wr_en;
  assign wr_slot = hit_q ? hit_pos_q : free_pos_q;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctl        = '0;
    head_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        ctl.shift = 1'b1;
        if (cnt_q == CW'(ENTRIES - 1)) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // second rotation used only for write-back
        ctl.shift = wr_en;
        ctl.load  = wr_en && cnt_q == CW'(ENTRIES - 1) - wr_slot;
        head_load = ctl.load;
        if (!wr_en && (sent_q || out_ready_i)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // The head takes the new entry while the last cell holds the target slot,
  // so the new entry lands in that slot's place in the ring.
  logic wr_pend_q, sent_q;
  assign wr_en = wr_pend_q;

  logic [31:0] age;
  assign age = adv_q.stamp - hit_ent_q.stamp;

  // table write needed: add, stale replace or newer sequence
  logic upd_d;
  always_comb begin
    if (adv_q.near_key[47:16] == local_id_q) upd_d = 1'b0;
    else if (!hit_q)                          upd_d = free_q;
    else upd_d = (age > limit_q) || (hit_ent_q.seq < adv_q.seq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
      sent_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          cnt_q  <= '0;
          sent_q <= 1'b0;
        end
        ST_SCAN: cnt_q <= (cnt_q == CW'(ENTRIES - 1)) ? '0 : cnt_q + 1'b1;
        ST_DECIDE: begin
          cnt_q     <= '0;
          wr_pend_q <= upd_d;
        end
        ST_OUT: begin
          if (wr_en) begin
            cnt_q <= (cnt_q == CW'(ENTRIES - 1)) ? '0 : cnt_q + 1'b1;
            if (cnt_q == CW'(ENTRIES - 1)) wr_pend_q <= 1'b0;
          end
          if (out_valid_o && out_ready_i) sent_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = state_q == ST_OUT && !sent_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      adv_q <= '{near_key: {in_rt_id_i, in_if_id_i},
                 far_key:  {in_n_rt_id_i, in_n_if_id_i},
                 payload:  {in_addr_i, in_metric_i, in_link_state_i},
                 seq:      in_seq_i, stamp: now_us_i};
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end
    if (state_q == ST_SCAN) begin
      // lowest slot wins: slot 0 is seen first, then descending from ENTRIES-1
      if (key_eq && (!hit_q || slot < hit_pos_q)) begin
        hit_q <= 1'b1; hit_pos_q <= slot; hit_ent_q <= ent[0];
      end
      if (!valid[0] && (!free_q || slot < free_pos_q)) begin
        free_q <= 1'b1; free_pos_q <= slot;
      end
    end
    if (state_q == ST_DECIDE) begin
      res_q <= adv_q;
      if (adv_q.near_key[47:16] == local_id_q) begin
        if (hit_q && hit_ent_q.seq != adv_q.seq) begin
          act_q <= ACT_LCL_FLD; res_q <= hit_ent_q;
        end else act_q <= ACT_LCL_DROP;
      end else if (!hit_q) begin
        if (free_q) act_q <= ACT_ADDED;
        else act_q <= ACT_FULL;
      end else if (age > limit_q) begin
        act_q <= ACT_STALE;
      end else if (hit_ent_q.seq < adv_q.seq) begin
        act_q <= ACT_NEWER;
      end else if (hit_ent_q.seq > adv_q.seq) begin
        act_q <= ACT_FLOOD; res_q <= hit_ent_q;
      end else act_q <= ACT_DROP;
    end
  end

  assign action_o         = act_q;
  assign out_rt_id_o      = res_q.near_key[47:16];
  assign out_if_id_o      = res_q.near_key[15:0];
  assign out_n_rt_id_o    = res_q.far_key[47:16];
  assign out_n_if_id_o    = res_q.far_key[15:0];
  assign out_addr_o       = res_q.payload[55:24];
  assign out_metric_o     = res_q.payload[23:8];
  assign out_link_state_o = res_q.payload[7:0];
  assign out_seq_o        = res_q.seq;

  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && cnt_q == CW'(ENTRIES - 1) |=> state_q == ST_DECIDE)
    else $error("scan length wrong");
  a_no_out_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> !out_valid_o)
    else $error("result during scan");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o && !wr_pend_q)
    else $error("accept while busy");

endmodule
`default_nettype wire
